### rtl/upsc_pkg.sv
`timescale 1ns / 1ps
// upsc_pkg: shared types, codes and helpers for the integer nearest upscaler
// no dependencies; used by the channel interfaces and the top level
package upsc_pkg;

	localparam int PIX_W      = 24;
	localparam int REP_W      = 5;
	localparam int SCALE_W    = 5;
	localparam int WIDTH_W    = 11;
	localparam int ROWS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_RUN = 2'd0,
		KIND_PAD = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// one item waiting after the line store read
	typedef struct packed {
		kind_t             kind;
		logic              use_ram;
		logic [PIX_W-1:0]  pixel;
		logic [REP_W-1:0]  rep;
		logic              has_pad;
		logic [1:0]        pad;
		logic              image_end;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [PIX_W-1:0]  out_pixel;
		logic [REP_W-1:0]  repeat_res;
		logic              image_end;
		logic              last;
	} word_t;

	// zero bytes that bring width * scale * 3 bytes to a multiple of 4
	function automatic logic [1:0] pad_bytes(input logic [1:0] w2, input logic [1:0] s2);
		logic [3:0] prod;
		logic [3:0] triple;
		prod   = w2 * s2;
		triple = prod[1:0] * 2'd3;
		return 2'd0 - triple[1:0];
	endfunction

endpackage

### rtl/upsc_if.sv
`timescale 1ns / 1ps
// upsc_in_if / upsc_out_if: valid-ready channels for pixel input and results
// depends on upsc_pkg
interface upsc_in_if import upsc_pkg::*; ();
	logic              valid;
	logic              ready;
	op_t               op;
	logic [PIX_W-1:0]  pixel;

	modport source (output valid, output op, output pixel, input ready);
	modport sink (input valid, input op, input pixel, output ready);
endinterface

interface upsc_out_if import upsc_pkg::*; ();
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [PIX_W-1:0]  out_pixel;
	logic [REP_W-1:0]  repeat_res;
	logic              image_end;
	logic              last;

	modport source (output valid, output kind, output out_pixel, output repeat_res,
		output image_end, output last, input ready);
	modport sink (input valid, input kind, input out_pixel, input repeat_res,
		input image_end, input last, output ready);
endinterface

### rtl/upsc_ram.sv
`timescale 1ns / 1ps
// upsc_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module upsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/integer_nearest_upscaler.sv
`timescale 1ns / 1ps
// integer_nearest_upscaler: nearest-neighbor row replication with a line store
// depends on upsc_pkg, upsc_if (upsc_in_if, upsc_out_if) and upsc_ram
//
//   port    dir   word                                         accepted when
//   pix     in    op, pixel                                    valid && ready
//   res     out   kind, out_pixel, repeat_res, image_end, last valid && ready
//   cfg     in    cfg_index, cfg_data                          cfg_we
//
// one input word per cycle unless the result path stalls; a word that closes a row also
// yields a padding word, so it holds the result path until both words have moved on
// the line store is read at acceptance and its registered data is held until the item moves on
// the result register takes a new word only when it is empty or its word is taken in that cycle
// arst_n clears counters and valid flags; configuration registers return to 1, the store
// holds whatever it held
module integer_nearest_upscaler import upsc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	upsc_in_if.sink               pix,
	upsc_out_if.source            res
);

	localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CW   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int CMPW = ((CW > REP_W) ? CW : REP_W) + 1;

	logic [SCALE_W-1:0] scale_q;
	logic [WIDTH_W-1:0] width_q;
	logic [ROWS_W-1:0]  rows_q;

	logic [AW-1:0]      column_q;
	logic [CW-1:0]      copy_q;
	logic [ROWS_W-1:0]  row_q;
	logic               replay_q;

	logic [REP_W-1:0]   eff_s;
	logic [WW-1:0]      eff_w;
	logic [ROWS_W-1:0]  eff_rows;
	logic               col_end, copy_end, row_end;
	logic [1:0]         pad;

	logic               acc, is_pix, wr_en, rd_en, enter;
	logic               valid_s1, phase_s1;
	item_t              item_s1, item_new;
	logic [PIX_W-1:0]   ram_rdata;
	word_t              word_s1, out_q;
	logic               out_valid_q, out_free, s1_move, s1_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			width_q <= WIDTH_W'(1);
			rows_q  <= ROWS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				CFG_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				CFG_ROWS:  rows_q  <= cfg_data[ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective bounds: zero acts as one, large scale and width values saturate
	always_comb begin
		if (scale_q == '0) begin
			eff_s = REP_W'(1);
		end else if (32'(scale_q) > MAX_SCALE) begin
			eff_s = REP_W'(MAX_SCALE);
		end else begin
			eff_s = REP_W'(scale_q);
		end
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		eff_rows = (rows_q == '0) ? ROWS_W'(1) : rows_q;
	end

	assign col_end  = (WW'(column_q) + WW'(1)) >= eff_w;
	assign copy_end = (CMPW'(copy_q) + CMPW'(1)) >= CMPW'(eff_s);
	assign row_end  = ({1'b0, row_q} + 17'd1) >= {1'b0, eff_rows};
	assign pad      = pad_bytes(2'(eff_w), 2'(eff_s));

	assign acc    = pix.valid && pix.ready;
	assign is_pix = (pix.op == OP_PIXEL);
	assign wr_en  = acc && is_pix && !replay_q;
	assign rd_en  = acc && !is_pix && replay_q;
	assign enter  = acc && (is_pix || replay_q);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			copy_q   <= '0;
			row_q    <= '0;
			replay_q <= 1'b0;
		end else if (wr_en || rd_en) begin
			if (col_end) begin
				column_q <= '0;
				if (wr_en) begin
					if (eff_s > REP_W'(1)) begin
						replay_q <= 1'b1;
						copy_q   <= CW'(1);
					end else begin
						row_q <= row_end ? '0 : row_q + ROWS_W'(1);
					end
				end else if (copy_end) begin
					replay_q <= 1'b0;
					copy_q   <= '0;
					row_q    <= row_end ? '0 : row_q + ROWS_W'(1);
				end else begin
					copy_q <= CW'(copy_q + CW'(1));
				end
			end else begin
				column_q <= AW'(column_q + AW'(1));
			end
		end
	end

	upsc_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (wr_en),
		.waddr (column_q),
		.wdata (pix.pixel),
		.re    (rd_en),
		.raddr (column_q),
		.rdata (ram_rdata)
	);

	// item captured at acceptance of a pixel or a replay drain, refused pixel becomes an error word
	always_comb begin
		item_new.kind      = (is_pix && replay_q) ? KIND_ERR : KIND_RUN;
		item_new.use_ram   = !is_pix;
		item_new.pixel     = replay_q ? '0 : pix.pixel;
		item_new.rep       = (is_pix && replay_q) ? '0 : eff_s;
		item_new.has_pad   = !(is_pix && replay_q) && col_end;
		item_new.pad       = pad;
		item_new.image_end = col_end && row_end && (wr_en ? (eff_s <= REP_W'(1)) : copy_end);
	end

	always_comb begin
		if (phase_s1) begin
			word_s1.kind       = KIND_PAD;
			word_s1.out_pixel  = '0;
			word_s1.repeat_res = REP_W'(item_s1.pad);
			word_s1.image_end  = item_s1.image_end;
			word_s1.last       = 1'b1;
		end else begin
			word_s1.kind       = item_s1.kind;
			word_s1.out_pixel  = item_s1.use_ram ? ram_rdata : item_s1.pixel;
			word_s1.repeat_res = item_s1.rep;
			word_s1.image_end  = 1'b0;
			word_s1.last       = !item_s1.has_pad;
		end
	end

	assign out_free  = !out_valid_q || res.ready;
	assign s1_move   = valid_s1 && out_free;
	assign s1_done   = s1_move && (phase_s1 || !item_s1.has_pad);
	assign pix.ready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (enter) begin
				valid_s1 <= 1'b1;
				phase_s1 <= 1'b0;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
				phase_s1 <= 1'b0;
			end else if (s1_move) begin
				phase_s1 <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enter) begin
			item_s1 <= item_new;
		end
		if (s1_move) begin
			out_q <= word_s1;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = out_q.kind;
	assign res.out_pixel  = out_q.out_pixel;
	assign res.repeat_res = out_q.repeat_res;
	assign res.image_end  = out_q.image_end;
	assign res.last       = out_q.last;

`ifndef NO_ASSERTIONS
	a_copy_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		replay_q |-> copy_q != '0)
		else $error("copy index zero while replaying");

	a_copy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!replay_q |-> copy_q == '0)
		else $error("copy index left over outside replay");

	a_phase_has_pad: assert property (@(posedge clk) disable iff (!arst_n)
		phase_s1 |-> valid_s1 && item_s1.has_pad)
		else $error("padding phase without a padding word");

	a_pad_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last && res.ready |=> out_valid_q && out_q.kind == KIND_PAD)
		else $error("run word not followed by its padding word");
`endif

endmodule

### verif/upsc_checker.sv
`timescale 1ns / 1ps
// upsc_checker: predicts the result words of integer_nearest_upscaler and compares them
// watches the pixel, result and config ports; depends on upsc_pkg and upsc_if
module upsc_checker import upsc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	upsc_in_if                    pix,
	upsc_out_if                   res,
	output int unsigned           fail_count,
	output int unsigned           pending,
	output logic                  replay_busy,
	output int unsigned           row_column
);

	logic [PIX_W-1:0]   line_copy [MAX_WIDTH];
	int unsigned        col_pos;
	int unsigned        copies_done;
	int unsigned        row_pos;
	logic               replay_on;
	logic [SCALE_W-1:0] scale_reg;
	logic [WIDTH_W-1:0] width_reg;
	logic [ROWS_W-1:0]  rows_reg;
	word_t              expected_words [$];
	word_t              oldest;

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (fail_count < 50)
			$display("%0t ns: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
		fail_count++;
	endtask

	function automatic word_t make_word(input kind_t k, input logic [PIX_W-1:0] px,
		input int unsigned rep, input logic img_end, input logic fin);
		word_t w;
		w.kind       = k;
		w.out_pixel  = px;
		w.repeat_res = REP_W'(rep);
		w.image_end  = img_end;
		w.last       = fin;
		return w;
	endfunction

	// moves to the next input row; high when that closes the image
	function automatic logic advance_row(input int unsigned rows);
		if (row_pos + 1 >= rows) begin
			row_pos = 0;
			return 1'b1;
		end
		row_pos = (row_pos + 1) & 32'hFFFF;
		return 1'b0;
	endfunction

	task automatic predict_results(input op_t op, input logic [PIX_W-1:0] px);
		int unsigned s;
		int unsigned w;
		int unsigned rows;
		int unsigned idx;
		int unsigned pad;
		logic        row_end;
		logic        img_end;
		logic [PIX_W-1:0] run_px;
		s    = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : scale_reg);
		w    = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		rows = (rows_reg == 0) ? 1 : rows_reg;
		idx  = col_pos % MAX_WIDTH;
		pad  = (4 - ((w * s * 3) & 3)) & 3;
		row_end = (col_pos + 1 >= w);
		img_end = 1'b0;
		if (op == OP_PIXEL && replay_on) begin
			expected_words.push_back(make_word(KIND_ERR, '0, 0, 1'b0, 1'b1));
		end else if (op == OP_PIXEL || replay_on) begin
			if (op == OP_PIXEL) begin
				line_copy[idx] = px;
				run_px = px;
			end else begin
				run_px = line_copy[idx];
			end
			expected_words.push_back(make_word(KIND_RUN, run_px, s, 1'b0, !row_end));
			if (row_end) begin
				col_pos = 0;
				if (op == OP_PIXEL) begin
					if (s > 1) begin
						replay_on   = 1'b1;
						copies_done = 1;
					end else begin
						img_end = advance_row(rows);
					end
				end else if (copies_done + 1 >= s) begin
					replay_on   = 1'b0;
					copies_done = 0;
					img_end     = advance_row(rows);
				end else begin
					copies_done = (copies_done + 1) & 32'hF;
				end
				expected_words.push_back(make_word(KIND_PAD, '0, pad, img_end, 1'b1));
			end else begin
				col_pos++;
			end
		end
		// a drain word with nothing to replay yields no result
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos     = 0;
			copies_done = 0;
			row_pos     = 0;
			replay_on   = 1'b0;
			scale_reg   = 1;
			width_reg   = 1;
			rows_reg    = 1;
			fail_count  = 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCALE: begin
						scale_reg = cfg_data[SCALE_W-1:0];
					end
					CFG_WIDTH: begin
						width_reg = cfg_data[WIDTH_W-1:0];
					end
					CFG_ROWS: begin
						rows_reg = cfg_data[ROWS_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (pix.valid && pix.ready)
				predict_results(pix.op, pix.pixel);
			if (res.valid && res.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word, kind", '0, res.kind);
				end else begin
					oldest = expected_words.pop_front();
					if (res.kind !== oldest.kind)
						report_mismatch("kind", oldest.kind, res.kind);
					if (res.out_pixel !== oldest.out_pixel)
						report_mismatch("out_pixel", oldest.out_pixel, res.out_pixel);
					if (res.repeat_res !== oldest.repeat_res)
						report_mismatch("repeat_res", oldest.repeat_res, res.repeat_res);
					if (res.image_end !== oldest.image_end)
						report_mismatch("image_end", oldest.image_end, res.image_end);
					if (res.last !== oldest.last)
						report_mismatch("last", oldest.last, res.last);
				end
			end
		end
		pending     = expected_words.size();
		replay_busy = replay_on;
		row_column  = col_pos;
	end

endmodule

### verif/tb_integer_nearest_upscaler.sv
`timescale 1ns / 1ps
// tb_integer_nearest_upscaler: stimulus, flow control and verdict for the upscaler
// depends on upsc_pkg, upsc_if, integer_nearest_upscaler and upsc_checker
module tb_integer_nearest_upscaler;
	import upsc_pkg::*;

	localparam int          MAX_WIDTH    = 1024;
	localparam int          MAX_SCALE    = 16;
	localparam int unsigned RANDOM_ITEMS = 800;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_SLACK  = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	upsc_in_if  pix_ch ();
	upsc_out_if res_ch ();

	int unsigned fail_count;
	int unsigned pending;
	logic        replay_busy;
	int unsigned row_column;

	int unsigned src_idle_pct = 18;
	int unsigned snk_idle_pct = 62;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned random_words = 0;
	int unsigned pick;
	int unsigned new_scale;
	int unsigned new_width;
	int unsigned new_rows;

	integer_nearest_upscaler #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix_ch),
		.res      (res_ch)
	);

	upsc_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix        (pix_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.replay_busy(replay_busy),
		.row_column (row_column)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic logic [PIX_W-1:0] rand_pixel();
		return PIX_W'($urandom());
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input op_t op, input logic [PIX_W-1:0] px);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.op    <= op;
		pix_ch.pixel <= px;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	task automatic set_config(input int unsigned s, input int unsigned w,
		input int unsigned r);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCALE;
		cfg_data  <= CFG_DATA_W'(s);
		@(negedge clk);
		cfg_index <= CFG_WIDTH;
		cfg_data  <= CFG_DATA_W'(w);
		@(negedge clk);
		cfg_index <= CFG_ROWS;
		cfg_data  <= CFG_DATA_W'(r);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic pick_idle();
		if (random_words < RANDOM_ITEMS / 3) begin
			src_idle_pct <= 18;
			snk_idle_pct <= 62;
		end else if (random_words < 2 * RANDOM_ITEMS / 3) begin
			src_idle_pct <= 62;
			snk_idle_pct <= 18;
		end else begin
			src_idle_pct <= 0;
			snk_idle_pct <= 0;
		end
	endtask

	// one input row and its replays, with some ignored drains and refused pixels
	task automatic stream_row();
		if ($urandom_range(99) < 8)
			send_word(OP_DRAIN, rand_pixel());
		do begin
			send_word(OP_PIXEL, rand_pixel());
			random_words++;
		end while (!replay_busy && row_column != 0);
		while (replay_busy) begin
			if ($urandom_range(99) < 6)
				send_word(OP_PIXEL, rand_pixel());
			else
				send_word(OP_DRAIN, rand_pixel());
			random_words++;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_SCALE;
		cfg_data     = '0;
		pix_ch.valid = 1'b0;
		pix_ch.op    = OP_PIXEL;
		pix_ch.pixel = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: two rows of two pixels at scale 3, image of two rows
		set_config(3, 2, 2);
		send_word(OP_DRAIN, 24'h0F0F0F);
		send_word(OP_PIXEL, 24'h000000);
		send_word(OP_PIXEL, 24'hFFFFFF);
		send_word(OP_PIXEL, 24'h5A5A5A);
		repeat (4) send_word(OP_DRAIN, 24'h000000);
		send_word(OP_PIXEL, 24'hA5A5A5);
		send_word(OP_PIXEL, 24'h123456);
		repeat (4) send_word(OP_DRAIN, 24'hFFFFFF);
		wait_drained();
		// scale 1: no replay, every row closes the image
		set_config(1, 1, 1);
		send_word(OP_PIXEL, 24'h800001);
		send_word(OP_DRAIN, 24'h7FFFFE);
		wait_drained();
		// width shrinks below the current column
		set_config(2, 3, 3);
		send_word(OP_PIXEL, 24'h00FF00);
		send_word(OP_PIXEL, 24'hFF00FF);
		wait_drained();
		set_config(2, 1, 3);
		send_word(OP_PIXEL, 24'h0000FF);
		send_word(OP_DRAIN, 24'h000000);
		wait_drained();
		// scale drops so that the replay copy already reached is the last one
		set_config(4, 2, 3);
		send_word(OP_PIXEL, 24'hC3C3C3);
		send_word(OP_PIXEL, 24'h3C3C3C);
		send_word(OP_DRAIN, 24'h000000);
		wait_drained();
		set_config(2, 2, 3);
		send_word(OP_DRAIN, 24'h000000);
		wait_drained();

		// full-width row with saturated width: writes the whole line store
		set_config(0, 2047, 0);
		for (int unsigned i = 0; i < MAX_WIDTH; i++) begin
			if (i == 300)
				hold_asks <= hold_asks + 1;
			if (i == 700)
				wait_drained();
			send_word(OP_PIXEL, rand_pixel());
		end
		wait_drained();

		// widest row and largest scale, left unfinished for the next setting
		set_config(16, 1024, 65535);
		repeat (25) send_word(OP_PIXEL, rand_pixel());

		while (random_words < RANDOM_ITEMS) begin
			wait_drained();
			pick_idle();
			pick = $urandom_range(99);
			new_scale = (pick < 8) ? 0 : (pick < 16) ? $urandom_range(17, 31) :
				(pick < 30) ? 16 : $urandom_range(1, 15);
			pick = $urandom_range(99);
			new_width = (pick < 8) ? 0 : (pick < 15) ? 1 : $urandom_range(2, 12);
			pick = $urandom_range(99);
			new_rows = (pick < 10) ? 0 : (pick < 18) ? 65535 : $urandom_range(1, 4);
			set_config(new_scale, new_width, new_rows);
			repeat ($urandom_range(1, 3)) stream_row();
		end
		wait_drained();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
